### src/sts_pkg.sv
// Shared types, constants and helpers for the sensor triple voltage scaler.
`default_nettype none
package sts_pkg;

  localparam int A_W      = 46;
  localparam int LANE_LAT = 11;
  localparam int HSV_LAT  = 11;

  localparam logic [1:0] ST_ERROR = 2'd0;
  localparam logic [1:0] ST_MEAS  = 2'd1;
  localparam logic [1:0] ST_IDLE  = 2'd2;

  localparam logic [2:0] REG_COLOR_MODE   = 3'd0;
  localparam logic [2:0] REG_VOLTAGE_MODE = 3'd1;
  localparam logic [2:0] REG_MIN_X        = 3'd2;
  localparam logic [2:0] REG_MAX_X        = 3'd3;
  localparam logic [2:0] REG_MIN_Y        = 3'd4;
  localparam logic [2:0] REG_MAX_Y        = 3'd5;
  localparam logic [2:0] REG_MIN_Z        = 3'd6;
  localparam logic [2:0] REG_MAX_Z        = 3'd7;

  localparam logic signed [14:0] LOW_BIPOLAR = -15'sd5000;
  localparam logic signed [14:0] SPAN_MV     = 15'sd10000;

  // floor(2^32 / 120) and floor(2^24 / 15)
  localparam logic [63:0] RECIP120 = 64'd35791394;
  localparam logic [40:0] RECIP15  = 41'd1118481;

  typedef struct packed {
    logic signed [A_W-1:0] ax;
    logic signed [A_W-1:0] ay;
    logic signed [A_W-1:0] az;
    logic [1:0]            status;
  } axes_t;

  // quotient of a 20-bit value by 15, value below 15 * 2^16
  function automatic logic [15:0] div15_q(input logic [19:0] val);
    logic [40:0] p;
    logic [19:0] q;
    logic [19:0] r;
    p = 41'(val) * RECIP15;
    q = 20'(p >> 24);
    r = val - 20'(q * 20'd15);
    if (r >= 20'd15) begin
      q = q + 20'd1;
    end
    return q[15:0];
  endfunction

endpackage
`default_nettype wire

### src/sts_hsv.sv
// Front pipeline: HSV to RGB conversion or whole-number truncation per axis.
`default_nettype none
module sts_hsv #(
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 color_mode,
  input  wire                 in_valid,
  input  wire signed [31:0]   value_x,
  input  wire signed [31:0]   value_y,
  input  wire signed [31:0]   value_z,
  input  wire                 is_measuring,
  input  wire                 has_error,
  output logic                out_valid,
  output sts_pkg::axes_t      out_axes
);
  import sts_pkg::*;

  typedef enum logic [2:0] {
    SEC_CX0, SEC_XC0, SEC_0CX, SEC_0XC, SEC_X0C, SEC_C0X
  } sec_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [33:0] m;
    sec_t               sec;
    logic               xneg;
    logic signed [32:0] nx;
    logic signed [32:0] ny;
    logic signed [32:0] nz;
    logic [1:0]         st;
  } carry_t;

  localparam logic [32:0] FMASK = 33'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [34:0] D60 = 35'(64'sd60 <<< FRAC_BITS);
  localparam logic signed [35:0] B60  = 36'(64'sd60 <<< FRAC_BITS);
  localparam logic signed [35:0] B120 = 36'(64'sd120 <<< FRAC_BITS);
  localparam logic signed [35:0] B180 = 36'(64'sd180 <<< FRAC_BITS);
  localparam logic signed [35:0] B240 = 36'(64'sd240 <<< FRAC_BITS);
  localparam logic signed [35:0] B300 = 36'(64'sd300 <<< FRAC_BITS);
  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

  function automatic logic signed [32:0] trunc_whole(input logic signed [31:0] x);
    logic signed [32:0] xe;
    logic [32:0]        ab;
    logic [32:0]        sh;
    xe = x;
    ab = x[31] ? 33'(-xe) : 33'(xe);
    sh = ab >> FRAC_BITS;
    return x[31] ? -$signed(sh) : $signed(sh);
  endfunction

  // stage 1
  logic               v1;
  logic signed [31:0] h1, s1, val1, y1, z1;
  logic [1:0]         st1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      h1   <= value_x;
      s1   <= value_y;
      val1 <= value_z;
      y1   <= value_y;
      z1   <= value_z;
      st1  <= has_error ? ST_ERROR : (is_measuring ? ST_MEAS : ST_IDLE);
    end
  end

  // stage 2: chroma product, hue reduction estimate
  logic signed [32:0] h1e;
  logic [32:0]        habs;
  logic [31:0]        hint;
  logic               v2;
  logic signed [63:0] vs2;
  logic [31:0]        hint2, hqe2;
  logic [23:0]        hfrac2;
  logic               hneg2;
  logic signed [31:0] h2, val2;
  logic signed [32:0] nx2, ny2, nz2;
  logic [1:0]         st2;

  assign h1e  = h1;
  assign habs = h1[31] ? 33'(-h1e) : 33'(h1e);
  assign hint = 32'(habs >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      vs2    <= 64'(val1) * 64'(s1);
      hint2  <= hint;
      hqe2   <= 32'((64'(hint) * RECIP120) >> 32);
      hfrac2 <= 24'(habs & FMASK);
      hneg2  <= h1[31];
      h2     <= h1;
      val2   <= val1;
      nx2    <= trunc_whole(h1);
      ny2    <= trunc_whole(y1);
      nz2    <= trunc_whole(z1);
      st2    <= st1;
    end
  end

  // stage 3: chroma, signed hue remainder
  logic               vsneg;
  logic [63:0]        vsabs, vssh;
  logic signed [63:0] ct;
  logic signed [31:0] c_next;
  logic [31:0]        rr0, rr;
  logic [32:0]        rmag;
  logic               v3;
  logic signed [31:0] c3, h3, val3;
  logic signed [33:0] r3;
  logic signed [32:0] nx3, ny3, nz3;
  logic [1:0]         st3;

  always_comb begin
    vsneg = vs2[63];
    vsabs = vsneg ? 64'(-vs2) : 64'(vs2);
    vssh  = vsabs >> FRAC_BITS;
    ct    = vsneg ? -$signed(vssh) : $signed(vssh);
    if (ct > I32_MAX) begin
      c_next = 32'(I32_MAX);
    end else if (ct < I32_MIN) begin
      c_next = 32'(I32_MIN);
    end else begin
      c_next = 32'(ct);
    end
    rr0 = hint2 - 32'(hqe2 * 32'd120);
    rr  = (rr0 >= 32'd120) ? rr0 - 32'd120 : rr0;
    rmag = (33'(rr) << FRAC_BITS) | 33'(hfrac2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      c3   <= c_next;
      r3   <= hneg2 ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      h3   <= h2;
      val3 <= val2;
      nx3  <= nx2;
      ny3  <= ny2;
      nz3  <= nz2;
      st3  <= st2;
    end
  end

  // stage 4: k, m, sector
  logic signed [34:0] t4, ta4;
  logic signed [35:0] h3e;
  sec_t               sec_next;
  logic               v4;
  logic signed [31:0] c4;
  logic signed [34:0] k4;
  logic signed [33:0] m4;
  sec_t               sec4;
  logic signed [32:0] nx4, ny4, nz4;
  logic [1:0]         st4;

  always_comb begin
    t4  = 35'(r3) - D60;
    ta4 = t4[34] ? -t4 : t4;
    h3e = h3;
    if (h3e < B60) begin
      sec_next = SEC_CX0;
    end else if (h3e < B120) begin
      sec_next = SEC_XC0;
    end else if (h3e < B180) begin
      sec_next = SEC_0CX;
    end else if (h3e < B240) begin
      sec_next = SEC_0XC;
    end else if (h3e < B300) begin
      sec_next = SEC_X0C;
    end else begin
      sec_next = SEC_C0X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      c4   <= c3;
      k4   <= D60 - ta4;
      m4   <= 34'(val3) - 34'(c3);
      sec4 <= sec_next;
      nx4  <= nx3;
      ny4  <= ny3;
      nz4  <= nz3;
      st4  <= st3;
    end
  end

  // stage 5: |C| * |k|, pre-shifted by four * ONE
  // stages 6..9: divide by 15, sixteen quotient bits per stage
  logic [31:0] cabs, kabs;
  logic [63:0] dv [5];
  logic [63:0] qv [5];
  logic [3:0]  rm [5];
  carry_t      cy [5];
  logic [4:0]  vd;
  logic [19:0] dval [4];
  logic [15:0] dq [4];
  logic [19:0] drem [4];

  assign cabs = c4[31] ? 32'(-c4) : 32'(c4);
  assign kabs = k4[34] ? 32'(-k4) : 32'(k4);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dval[j] = {rm[j], dv[j][63:48]};
      dq[j]   = div15_q(dval[j]);
      drem[j] = dval[j] - 20'(20'(dq[j]) * 20'd15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[3:0], v4};
    end
    if (en) begin
      dv[0]       <= (64'(cabs) * 64'(kabs)) >> (FRAC_BITS + 2);
      qv[0]       <= '0;
      rm[0]       <= '0;
      cy[0].c     <= c4;
      cy[0].m     <= m4;
      cy[0].sec   <= sec4;
      cy[0].xneg  <= c4[31] ^ k4[34];
      cy[0].nx    <= nx4;
      cy[0].ny    <= ny4;
      cy[0].nz    <= nz4;
      cy[0].st    <= st4;
      for (int j = 0; j < 4; j++) begin
        dv[j+1] <= {dv[j][47:0], 16'd0};
        qv[j+1] <= {qv[j][47:0], dq[j]};
        rm[j+1] <= drem[j][3:0];
        cy[j+1] <= cy[j];
      end
    end
  end

  // stage 10: channel sums
  logic signed [35:0] xs, ce;
  logic signed [35:0] pr, pg, pb;
  logic               v10;
  logic signed [36:0] sr10, sg10, sb10;
  logic signed [32:0] nx10, ny10, nz10;
  logic [1:0]         st10;

  always_comb begin
    xs = cy[4].xneg ? -$signed({1'b0, qv[4][34:0]}) : $signed({1'b0, qv[4][34:0]});
    ce = cy[4].c;
    unique case (cy[4].sec)
      SEC_CX0: begin pr = ce;  pg = xs;  pb = '0;  end
      SEC_XC0: begin pr = xs;  pg = ce;  pb = '0;  end
      SEC_0CX: begin pr = '0;  pg = ce;  pb = xs;  end
      SEC_0XC: begin pr = '0;  pg = xs;  pb = ce;  end
      SEC_X0C: begin pr = xs;  pg = '0;  pb = ce;  end
      SEC_C0X: begin pr = ce;  pg = '0;  pb = xs;  end
      default: begin pr = ce;  pg = '0;  pb = xs;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= vd[4];
    end
    if (en) begin
      sr10 <= 37'(pr) + 37'(cy[4].m);
      sg10 <= 37'(pg) + 37'(cy[4].m);
      sb10 <= 37'(pb) + 37'(cy[4].m);
      nx10 <= cy[4].nx;
      ny10 <= cy[4].ny;
      nz10 <= cy[4].nz;
      st10 <= cy[4].st;
    end
  end

  // stage 11: scale by 255 and drop the fraction toward zero
  function automatic logic signed [A_W-1:0] scale255(input logic signed [36:0] s);
    logic signed [45:0] p;
    logic [45:0]        ab;
    logic [45:0]        sh;
    p  = (46'(s) <<< 8) - 46'(s);
    ab = p[45] ? 46'(-p) : 46'(p);
    sh = ab >> FRAC_BITS;
    return p[45] ? -$signed(A_W'(sh)) : $signed(A_W'(sh));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v10;
    end
    if (en) begin
      out_axes.ax     <= color_mode ? scale255(sr10) : A_W'(nx10);
      out_axes.ay     <= color_mode ? scale255(sg10) : A_W'(ny10);
      out_axes.az     <= color_mode ? scale255(sb10) : A_W'(nz10);
      out_axes.status <= st10;
    end
  end

endmodule
`default_nettype wire

### src/sts_lane.sv
// One axis: linear range map onto millivolts with clamp and pipelined divider.
`default_nettype none
module sts_lane #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire                          bipolar,
  input  wire signed [31:0]            lo,
  input  wire signed [31:0]            hi,
  input  wire signed [sts_pkg::A_W-1:0] a,
  output logic signed [14:0]           volt
);
  import sts_pkg::*;

  typedef enum logic [1:0] {LC_LOW, LC_HIGH, LC_DIV} lcode_t;

  localparam int DSTEPS = 7;

  // stage 1
  logic signed [63:0] d1;
  logic signed [32:0] n1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= (64'(a) <<< FRAC_BITS) - 64'(lo);
      n1 <= 33'(hi) - 33'(lo);
    end
  end

  // stage 2: make the range positive
  logic signed [63:0] d2;
  logic [32:0]        n2;

  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= n1[32] ? -d1 : d1;
      n2 <= n1[32] ? 33'(-n1) : 33'(n1);
    end
  end

  // stage 3: classify, form numerator
  lcode_t      code_next;
  logic [46:0] rr [DSTEPS+1];
  logic [13:0] qq [DSTEPS+1];
  logic [32:0] nn [DSTEPS+1];
  lcode_t      cd [DSTEPS+1];

  always_comb begin
    if (n2 == '0 || d2 <= 64'sd0) begin
      code_next = LC_LOW;
    end else if ($unsigned(d2) >= 64'(n2)) begin
      code_next = LC_HIGH;
    end else begin
      code_next = LC_DIV;
    end
  end

  // restoring division, two quotient bits per stage
  logic [46:0] rn [DSTEPS];
  logic [13:0] qn [DSTEPS];
  logic [46:0] trial;

  always_comb begin
    trial = '0;
    for (int j = 0; j < DSTEPS; j++) begin
      rn[j] = rr[j];
      qn[j] = qq[j];
      for (int t = 0; t < 2; t++) begin
        trial = 47'(nn[j]) << (13 - 2 * j - t);
        if (rn[j] >= trial) begin
          rn[j] = rn[j] - trial;
          qn[j][13 - 2 * j - t] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= 47'(d2[32:0]) * 47'd10000;
      qq[0] <= '0;
      nn[0] <= n2;
      cd[0] <= code_next;
      for (int j = 0; j < DSTEPS; j++) begin
        rr[j+1] <= rn[j];
        qq[j+1] <= qn[j];
        nn[j+1] <= nn[j];
        cd[j+1] <= cd[j];
      end
    end
  end

  // final: offset and clamp
  logic signed [14:0] lowv;
  logic signed [14:0] add;

  always_comb begin
    lowv = bipolar ? LOW_BIPOLAR : 15'sd0;
    unique case (cd[DSTEPS])
      LC_LOW:  add = 15'sd0;
      LC_HIGH: add = SPAN_MV;
      LC_DIV:  add = $signed({1'b0, qq[DSTEPS]});
      default: add = 15'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      volt <= lowv + add;
    end
  end

endmodule
`default_nettype wire

### src/sensor_triple_to_voltage_scaler.sv
// Top level: configuration registers, pipeline control and output selection.
// Takes one reading per clock while in_stall is low. A reading passes through 11
// stages for the colour conversion, whose divide by sixty degrees runs as four
// 16-bit quotient stages, and then 11 for the range map, whose restoring
// divider makes two quotient bits per stage. The whole pipeline advances
// together; while a result waits with out_stall high, in_stall is high too.
// Configuration registers are read live and must be written while idle.
`default_nettype none
module sensor_triple_to_voltage_scaler #(
  parameter int FRAC_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  value_x,
  input  wire signed [31:0]  value_y,
  input  wire signed [31:0]  value_z,
  input  wire                is_measuring,
  input  wire                has_error,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [14:0] volt_x,
  output logic signed [14:0] volt_y,
  output logic signed [14:0] volt_z,
  output logic [1:0]         status_code
);
  import sts_pkg::*;

  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< FRAC_BITS);

  logic               color_mode;
  logic               voltage_mode;
  logic signed [31:0] lim [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      voltage_mode <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        lim[i] <= (i % 2 == 1) ? ONE : 32'sd0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        REG_VOLTAGE_MODE: voltage_mode <= cfg_data[0];
        REG_MIN_X:        lim[0]       <= cfg_data;
        REG_MAX_X:        lim[1]       <= cfg_data;
        REG_MIN_Y:        lim[2]       <= cfg_data;
        REG_MAX_Y:        lim[3]       <= cfg_data;
        REG_MIN_Z:        lim[4]       <= cfg_data;
        REG_MAX_Z:        lim[5]       <= cfg_data;
        default:          color_mode   <= color_mode;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic  hv;
  axes_t ha;

  sts_hsv #(.FRAC_BITS(FRAC_BITS)) u_hsv (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .color_mode   (color_mode),
    .in_valid     (in_valid),
    .value_x      (value_x),
    .value_y      (value_y),
    .value_z      (value_z),
    .is_measuring (is_measuring),
    .has_error    (has_error),
    .out_valid    (hv),
    .out_axes     (ha)
  );

  logic signed [14:0] lx, ly, lz;

  sts_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk (clk), .en (en), .bipolar (voltage_mode),
    .lo (lim[0]), .hi (lim[1]), .a (ha.ax), .volt (lx)
  );
  sts_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk (clk), .en (en), .bipolar (voltage_mode),
    .lo (lim[2]), .hi (lim[3]), .a (ha.ay), .volt (ly)
  );
  sts_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk (clk), .en (en), .bipolar (voltage_mode),
    .lo (lim[4]), .hi (lim[5]), .a (ha.az), .volt (lz)
  );

  logic [LANE_LAT-1:0] mv;
  logic [1:0]          mst [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[LANE_LAT-2:0], hv};
    end
    if (en) begin
      mst[0] <= ha.status;
      for (int i = 1; i < LANE_LAT; i++) begin
        mst[i] <= mst[i-1];
      end
    end
  end

  assign out_valid   = mv[LANE_LAT-1];
  assign status_code = mst[LANE_LAT-1];
  assign volt_x      = (status_code == ST_MEAS) ? lx : 15'sd0;
  assign volt_y      = (status_code == ST_MEAS) ? ly : 15'sd0;
  assign volt_z      = (status_code == ST_MEAS) ? lz : 15'sd0;

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output held");

  a_zero_volts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_code != ST_MEAS) |-> (volt_x == 0 && volt_y == 0 && volt_z == 0))
    else $error("nonzero voltage without measurement");

  a_unipolar: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !voltage_mode && status_code == ST_MEAS)
      |-> (!volt_x[14] && !volt_y[14] && !volt_z[14]))
    else $error("negative voltage in unipolar mode");

  a_bipolar: assert property (@(posedge clk) disable iff (rst)
    (out_valid && voltage_mode && status_code == ST_MEAS)
      |-> (volt_x >= -15'sd5000 && volt_x <= 15'sd5000))
    else $error("bipolar voltage out of range");
`endif

endmodule
`default_nettype wire

### test/tb_sensor_triple_to_voltage_scaler.sv
// Testbench for the sensor triple to voltage scaler: queued stimulus, live prediction, checks.
`timescale 1ns / 1ps
module tb_sensor_triple_to_voltage_scaler;
  import sts_pkg::*;

  localparam longint ONE = 64'sd1 <<< 16;
  localparam longint D60 = 60 * ONE;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               meas, err;
  } reading_t;

  typedef struct {
    logic signed [14:0] vx, vy, vz;
    logic [1:0]         st;
  } volts_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  wire in_stall, out_valid;
  logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
  logic is_measuring = 0, has_error = 0;
  wire signed [14:0] volt_x, volt_y, volt_z;
  wire [1:0] status_code;

  sensor_triple_to_voltage_scaler dut (.*);

  initial forever #5 clk = ~clk;

  reading_t pending_readings[$];
  volts_t   volt_expected[$];
  reading_t on_bus;
  bit       hsv_on, bipolar_on;
  longint   axis_lim[6];
  int       burst_left = 0, gap_left = 0, stall_mode = 0, stall_ctr = 0;
  int       mismatches = 0, cycles = 0;

  function automatic logic signed [14:0] map_axis(longint a, longint lo, longint hi, bit bip);
    longint low, d, n, mv;
    low = bip ? -5000 : 0;
    d = a * ONE - lo;
    n = hi - lo;
    if (n < 0) begin
      n = -n;
      d = -d;
    end
    if (n == 0 || d <= 0) mv = low;
    else if (d >= n) mv = low + 10000;
    else mv = low + (d * 10000) / n;
    return mv[14:0];
  endfunction

  function automatic void hsv_to_levels(longint h, longint s, longint v, output longint lv[3]);
    longint c, r, k, xx, m, dr;
    longint p[3];
    c = (v * s) / ONE;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    r = h % (2 * D60);
    dr = r - D60;
    k = D60 - (dr < 0 ? -dr : dr);
    xx = (c * k) / D60;
    m = v - c;
    if (h < D60)          p = '{c, xx, 0};
    else if (h < 2 * D60) p = '{xx, c, 0};
    else if (h < 3 * D60) p = '{0, c, xx};
    else if (h < 4 * D60) p = '{0, xx, c};
    else if (h < 5 * D60) p = '{xx, 0, c};
    else                  p = '{c, 0, xx};
    for (int i = 0; i < 3; i++) lv[i] = ((p[i] + m) * 255) / ONE;
  endfunction

  function automatic volts_t predict_volts(reading_t r);
    volts_t o;
    longint a[3];
    o = '{0, 0, 0, ST_MEAS};
    if (r.err || !r.meas) begin
      o.st = r.err ? ST_ERROR : ST_IDLE;
      return o;
    end
    if (hsv_on) hsv_to_levels(r.x, r.y, r.z, a);
    else begin
      a[0] = longint'(r.x) / ONE;
      a[1] = longint'(r.y) / ONE;
      a[2] = longint'(r.z) / ONE;
    end
    o.vx = map_axis(a[0], axis_lim[0], axis_lim[1], bipolar_on);
    o.vy = map_axis(a[1], axis_lim[2], axis_lim[3], bipolar_on);
    o.vz = map_axis(a[2], axis_lim[4], axis_lim[5], bipolar_on);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) volt_expected.push_back(predict_volts(on_bus));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pending_readings.size() > 0) begin
          on_bus = pending_readings.pop_front();
          value_x <= on_bus.x;
          value_y <= on_bus.y;
          value_z <= on_bus.z;
          is_measuring <= on_bus.meas;
          has_error <= on_bus.err;
          in_valid <= 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    stall_ctr++;
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (stall_ctr % 7) >= 4;
      default: out_stall <= 0;
    endcase
  end

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // monitor
  always @(posedge clk) begin
    volts_t e;
    if (!rst && out_valid && !out_stall) begin
      if (volt_expected.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer %0d %0d %0d st %0d",
                                volt_x, volt_y, volt_z, status_code));
      end else begin
        e = volt_expected.pop_front();
        if (volt_x !== e.vx) note_mismatch($sformatf("volt_x exp %0d got %0d", e.vx, volt_x));
        if (volt_y !== e.vy) note_mismatch($sformatf("volt_y exp %0d got %0d", e.vy, volt_y));
        if (volt_z !== e.vz) note_mismatch($sformatf("volt_z exp %0d got %0d", e.vz, volt_z));
        if (status_code !== e.st)
          note_mismatch($sformatf("status exp %0d got %0d", e.st, status_code));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      REG_COLOR_MODE:   hsv_on = val[0];
      REG_VOLTAGE_MODE: bipolar_on = val[0];
      default:          axis_lim[idx - REG_MIN_X] = longint'($signed(val));
    endcase
  endtask

  task automatic set_limits(logic [31:0] lo, logic [31:0] hi);
    for (int i = 0; i < 3; i++) begin
      write_reg(REG_MIN_X + 3'(2 * i), lo);
      write_reg(REG_MAX_X + 3'(2 * i), hi);
    end
  endtask

  task automatic add(longint x, longint y, longint z, bit meas = 1, bit err = 0);
    pending_readings.push_back('{32'(x), 32'(y), 32'(z), meas, err});
  endtask

  task automatic drain();
    wait (pending_readings.size() == 0 && !in_valid && volt_expected.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_limit(int kind);
    if (kind == 0) return $urandom;
    return 32'($signed($urandom_range(0, 600)) - 300) * 32'(ONE) + $urandom_range(0, 65535);
  endfunction

  initial begin
    int lk;
    hsv_on = 0;
    bipolar_on = 0;
    axis_lim = '{0, ONE, 0, ONE, 0, ONE};
    repeat (4) @(posedge clk);
    rst <= 0;

    // reset settings: flags, extremes, truncation toward zero
    add(0, ONE, ONE / 2);
    add(32'h7fffffff, 32'h80000000, -ONE);
    add(ONE - 1, -ONE + 1, 2 * ONE, 1, 1);
    add(ONE, ONE, ONE, 0, 0);
    add(ONE, ONE, ONE, 0, 1);
    drain();

    // colour: every hue sector, negative hue, out-of-range saturation/value
    write_reg(REG_COLOR_MODE, 1);
    set_limits(0, 32'(255 * ONE));
    for (int h = 0; h < 360; h += 30) add(h * ONE + 7, ONE, ONE);
    add(-30 * ONE, ONE, ONE);
    add(359 * ONE, ONE / 2, 3 * ONE / 4);
    add(500 * ONE, 2 * ONE, ONE);
    add(32'h80000000, 32'h80000000, 32'h80000000);
    add(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    drain();

    // bipolar, reversed range on x, empty range on z, widest limits on y
    write_reg(REG_VOLTAGE_MODE, 1);
    write_reg(REG_COLOR_MODE, 0);
    write_reg(REG_MIN_X, 32'(100 * ONE));
    write_reg(REG_MAX_X, 32'(-100 * ONE));
    write_reg(REG_MIN_Y, 32'h80000000);
    write_reg(REG_MAX_Y, 32'h7fffffff);
    write_reg(REG_MIN_Z, 32'(5 * ONE));
    write_reg(REG_MAX_Z, 32'(5 * ONE));
    add(50 * ONE, 0, 5 * ONE);
    add(-150 * ONE, 32'h7fffffff, 6 * ONE);
    add(150 * ONE, 32'h80000000, 4 * ONE);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      stall_mode = ph % 3;
      write_reg(REG_COLOR_MODE, $urandom_range(0, 1));
      write_reg(REG_VOLTAGE_MODE, $urandom_range(0, 1));
      lk = $urandom_range(0, 3);
      if (hsv_on && lk >= 2) set_limits(0, 32'(255 * ONE));
      else
        for (int i = 0; i < 6; i++) write_reg(REG_MIN_X + 3'(i), rand_limit(lk));
      for (int n = 0; n < 175; n++) begin
        logic [31:0] v[3];
        bit meas, err;
        meas = 1;
        err = 0;
        if ($urandom_range(0, 6) == 0) begin
          meas = $urandom_range(0, 1);
          err = $urandom_range(0, 1);
        end
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(0, 3) == 0) v[i] = $urandom;
          else if (hsv_on)
            v[i] = (i == 0) ? 32'($signed($urandom_range(0, 400 * ONE)) - 20 * ONE)
                            : $urandom_range(0, ONE);
          else v[i] = 32'($signed($urandom_range(0, 800)) - 400) * 32'(ONE) + $urandom;
        end
        add($signed(v[0]), $signed(v[1]), $signed(v[2]), meas, err);
      end
      drain();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
